// File: src/lphm_pkg.sv
// Shared types and codes for the linear probing hash map unit.
`timescale 1ns / 1ps

package lphm_pkg;

  // Command codes
  localparam logic [2:0] CMD_GET    = 3'd0;
  localparam logic [2:0] CMD_SET    = 3'd1;
  localparam logic [2:0] CMD_ADD    = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_ZERO_HASH = 2'd3;

  // Last step of the key mixer
  localparam logic [2:0] MIX_LAST = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] key;
    logic [31:0] value_in;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [5:0]  entry_count;
  } out_t;

endpackage

// File: src/linear_probe_hash_map_unit.sv
// Linear probing hash map engine: slot memory, item memory and command sequencer.
`timescale 1ns / 1ps

// One command is handled at a time. A keyed command runs the key mixer and
// fetches the home slot. The probe checks each slot it visits, fetching the key
// from the item memory on a stored hash match, and it visits at most SLOT_COUNT
// slots. An insert writes the new slot and item, then the home slot count if
// the free slot is not the home slot. A removal empties the slot, drops the
// home count and refills the hole with the last item. A key whose hash is zero
// stops at the home fetch. Clear and unused codes go straight to the result:
// slots carry a valid flag that clear drops at once. Every command hands its
// result to the output register. The slot memory gives one read a cycle, and
// that sets the pace of the probe. A finished result waits in the output
// register, so the next command can be accepted while it is still stalled.
module linear_probe_hash_map_unit #(
  parameter int SLOT_COUNT = 64,
  parameter int ITEM_COUNT = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  lphm_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output lphm_pkg::out_t  out_data
);

  localparam int SLOT_BITS = $clog2(SLOT_COUNT);
  localparam int ITEM_BITS = $clog2(ITEM_COUNT);
  localparam int CNT_BITS  = $clog2(ITEM_COUNT + 1);

  typedef struct packed {
    logic [31:0]          hash;
    logic [ITEM_BITS-1:0] item;
    logic [CNT_BITS-1:0]  cnt;
  } slot_word_t;

  typedef struct packed {
    logic [63:0]           key;
    logic [VALUE_BITS-1:0] value;
    logic [SLOT_BITS-1:0]  slot;
  } item_word_t;

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_HASH = 17'h00002,
    S_HOME = 17'h00004,
    S_HW   = 17'h00008,
    S_FRD  = 17'h00010,
    S_FCHK = 17'h00020,
    S_FKEY = 17'h00040,
    S_IRD  = 17'h00080,
    S_ICHK = 17'h00100,
    S_IW1  = 17'h00200,
    S_IW2  = 17'h00400,
    S_REM1 = 17'h00800,
    S_REM2 = 17'h01000,
    S_REM3 = 17'h02000,
    S_REM4 = 17'h04000,
    S_REM5 = 17'h08000,
    S_DONE = 17'h10000
  } state_t;

  state_t state;

  // Memories
  slot_word_t slot_mem [SLOT_COUNT];
  item_word_t item_mem [ITEM_COUNT];
  logic [SLOT_COUNT-1:0] slot_valid;
  slot_word_t slot_rdata;
  logic       slot_rv;
  item_word_t item_rdata;

  // Command registers
  logic [2:0]            cmd;
  logic [63:0]           key;
  logic [VALUE_BITS-1:0] vin;
  logic [63:0]           hk;
  logic [2:0]            mix_step;
  logic [SLOT_BITS-1:0]  pos;
  logic [SLOT_BITS:0]    steps;
  logic [CNT_BITS-1:0]   left;
  logic [CNT_BITS-1:0]   total;
  slot_word_t            hw;
  slot_word_t            sw;
  item_word_t            iw;
  logic [1:0]            res_status;
  logic [31:0]           res_value;

  // Memory port controls
  logic                 slot_we;
  logic [SLOT_BITS-1:0] slot_wa;
  slot_word_t           slot_wd;
  logic [SLOT_BITS-1:0] slot_ra;
  logic                 item_we;
  logic [ITEM_BITS-1:0] item_wa;
  item_word_t           item_wd;
  logic [ITEM_BITS-1:0] item_ra;

  // Derived values
  slot_word_t           slot_rd;
  logic [31:0]          h;
  logic [SLOT_BITS-1:0] home;
  logic [CNT_BITS-1:0]  total_m1;
  logic [63:0]          vin_wide;
  logic [63:0]          vout_wide;
  logic [31:0]          total_wide;
  logic                 rd_home_match;
  logic                 rd_item_ok;
  logic                 table_full;
  logic                 steps_done;
  logic                 done_fire;

  assign slot_rd       = slot_rv ? slot_rdata : '0;
  assign h             = hk[31:0];
  assign home          = hk[SLOT_BITS-1:0];
  assign total_m1      = total - 1'b1;
  assign vin_wide      = {32'd0, in_data.value_in};
  assign vout_wide     = 64'(item_rdata.value);
  assign total_wide    = 32'(total);
  assign rd_home_match = (slot_rd.hash != 32'd0) && (slot_rd.hash[SLOT_BITS-1:0] == home);
  assign rd_item_ok    = ({1'b0, slot_rd.item} < (ITEM_BITS + 1)'(ITEM_COUNT));
  assign table_full    = (total >= CNT_BITS'(ITEM_COUNT));
  assign steps_done    = (steps == (SLOT_BITS + 1)'(SLOT_COUNT));
  assign done_fire     = (state == S_DONE) && (!out_valid || !out_stall);
  assign in_stall      = (state != S_IDLE);

  // Slot memory: registered read, valid flag per slot
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rdata <= slot_mem[slot_ra];
  end

  // Item memory: registered read
  always_ff @(posedge clk) begin
    if (item_we) begin
      item_mem[item_wa] <= item_wd;
    end
    item_rdata <= item_mem[item_ra];
  end

  // Memory addresses and writes per state
  always_comb begin
    slot_we = 1'b0;
    slot_wa = pos;
    slot_wd = sw;
    slot_ra = pos;
    item_we = 1'b0;
    item_wa = sw.item;
    item_wd = iw;
    item_ra = slot_rd.item;
    case (state)
      S_HOME: begin
        slot_ra = home;
      end
      S_FKEY: begin
        // update value of a set hit
        item_wa = sw.item;
        item_wd = '{key: item_rdata.key, value: vin, slot: item_rdata.slot};
      end
      S_IW1: begin
        slot_we = 1'b1;
        slot_wa = pos;
        slot_wd = '{hash: h, item: total[ITEM_BITS-1:0],
                    cnt: (pos == home) ? hw.cnt + 1'b1 : sw.cnt};
        item_we = 1'b1;
        item_wa = total[ITEM_BITS-1:0];
        item_wd = '{key: key, value: vin, slot: pos};
      end
      S_IW2: begin
        slot_we = 1'b1;
        slot_wa = home;
        slot_wd = '{hash: hw.hash, item: hw.item, cnt: hw.cnt + 1'b1};
      end
      S_REM1: begin
        slot_we = 1'b1;
        slot_wa = pos;
        slot_wd = '{hash: 32'd0, item: sw.item,
                    cnt: (pos == home) ? hw.cnt - 1'b1 : sw.cnt};
      end
      S_REM2: begin
        slot_we = 1'b1;
        slot_wa = home;
        slot_wd = '{hash: hw.hash, item: hw.item, cnt: hw.cnt - 1'b1};
      end
      S_REM3: begin
        item_ra = total_m1[ITEM_BITS-1:0];
      end
      S_REM4: begin
        // move the last item into the hole, then fetch its slot
        item_we = 1'b1;
        item_wa = sw.item;
        item_wd = item_rdata;
        slot_ra = item_rdata.slot;
      end
      S_REM5: begin
        slot_we = 1'b1;
        slot_wa = iw.slot;
        slot_wd = '{hash: slot_rd.hash, item: sw.item, cnt: slot_rd.cnt};
      end
      default: begin
      end
    endcase
    if (state == S_FKEY) begin
      item_we = (cmd == lphm_pkg::CMD_SET) && (item_rdata.key == key);
    end
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      total      <= '0;
      slot_valid <= '0;
      slot_rv    <= 1'b0;
    end else begin
      slot_rv <= slot_valid[slot_ra];
      if (slot_we) begin
        slot_valid[slot_wa] <= 1'b1;
      end
      if (done_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd        <= in_data.cmd;
            key        <= in_data.key;
            vin        <= vin_wide[VALUE_BITS-1:0];
            hk         <= in_data.key;
            mix_step   <= '0;
            res_status <= lphm_pkg::ST_OK;
            res_value  <= '0;
            if (in_data.cmd == lphm_pkg::CMD_CLEAR) begin
              slot_valid <= '0;
              total      <= '0;
              state      <= S_DONE;
            end else if (in_data.cmd > lphm_pkg::CMD_CLEAR) begin
              state <= S_DONE;
            end else begin
              state <= S_HASH;
            end
          end
        end
        // Key mixer, one step a cycle
        S_HASH: begin
          case (mix_step)
            3'd0:    hk <= (~hk) + (hk << 18);
            3'd1:    hk <= hk ^ (hk >> 31);
            // times 21 as shifts and adds
            3'd2:    hk <= hk + (hk << 2) + (hk << 4);
            3'd3:    hk <= hk ^ (hk >> 11);
            3'd4:    hk <= hk + (hk << 6);
            default: hk <= hk ^ (hk >> 22);
          endcase
          mix_step <= mix_step + 1'b1;
          if (mix_step == lphm_pkg::MIX_LAST) begin
            state <= S_HOME;
          end
        end
        S_HOME: begin
          pos   <= home;
          steps <= '0;
          if (h == 32'd0) begin
            res_status <= lphm_pkg::ST_ZERO_HASH;
            state      <= S_DONE;
          end else begin
            state <= S_HW;
          end
        end
        S_HW: begin
          hw   <= slot_rd;
          left <= slot_rd.cnt;
          if (cmd == lphm_pkg::CMD_ADD) begin
            if (table_full) begin
              res_status <= lphm_pkg::ST_FULL;
              state      <= S_DONE;
            end else begin
              state <= S_IRD;
            end
          end else begin
            state <= S_FRD;
          end
        end
        // Lookup probe
        S_FRD: begin
          if (left == '0 || steps_done) begin
            if (cmd == lphm_pkg::CMD_SET) begin
              pos   <= home;
              steps <= '0;
              if (table_full) begin
                res_status <= lphm_pkg::ST_FULL;
                state      <= S_DONE;
              end else begin
                state <= S_IRD;
              end
            end else begin
              res_status <= lphm_pkg::ST_NOT_FOUND;
              state      <= S_DONE;
            end
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          sw <= slot_rd;
          if (rd_home_match) begin
            left <= left - 1'b1;
          end
          if (rd_home_match && slot_rd.hash == h && rd_item_ok) begin
            state <= S_FKEY;
          end else begin
            pos   <= pos + 1'b1;
            steps <= steps + 1'b1;
            state <= S_FRD;
          end
        end
        S_FKEY: begin
          iw <= item_rdata;
          if (item_rdata.key == key) begin
            if (cmd == lphm_pkg::CMD_GET) begin
              res_value <= vout_wide[31:0] & 32'hFFFFFFFF;
              state     <= S_DONE;
            end else if (cmd == lphm_pkg::CMD_SET) begin
              state <= S_DONE;
            end else begin
              state <= S_REM1;
            end
          end else begin
            pos   <= pos + 1'b1;
            steps <= steps + 1'b1;
            state <= S_FRD;
          end
        end
        // Insert: first empty slot from home
        S_IRD: begin
          if (steps_done) begin
            res_status <= lphm_pkg::ST_FULL;
            state      <= S_DONE;
          end else begin
            state <= S_ICHK;
          end
        end
        S_ICHK: begin
          sw <= slot_rd;
          if (slot_rd.hash == 32'd0) begin
            state <= S_IW1;
          end else begin
            pos   <= pos + 1'b1;
            steps <= steps + 1'b1;
            state <= S_IRD;
          end
        end
        S_IW1: begin
          if (pos == home) begin
            total <= total + 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_IW2;
          end
        end
        S_IW2: begin
          total <= total + 1'b1;
          state <= S_DONE;
        end
        // Remove: empty the slot, drop home count, refill the item hole
        S_REM1: begin
          state <= (pos == home) ? S_REM3 : S_REM2;
        end
        S_REM2: begin
          state <= S_REM3;
        end
        S_REM3: begin
          if (CNT_BITS'(sw.item) != total_m1) begin
            state <= S_REM4;
          end else begin
            total <= total_m1;
            state <= S_DONE;
          end
        end
        S_REM4: begin
          iw    <= item_rdata;
          state <= S_REM5;
        end
        S_REM5: begin
          total <= total_m1;
          state <= S_DONE;
        end
        // Hand the result to the output register
        S_DONE: begin
          if (done_fire) begin
            out_data.status      <= res_status;
            out_data.value_out   <= res_value;
            out_data.entry_count <= total_wide[5:0];
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
